FILE: rtl/core/sstm_pkg.sv
`timescale 1ns / 1ps

package sstm_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int DATA_W    = 32;
    localparam int IDX_W     = $clog2(MAX_ITEMS);
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_START,
        S_SCAN,
        S_TGT_B,
        S_TGT_E,
        S_SWAP,
        S_NEXT,
        S_DONE
    } t_state;

    // status from the datapath to the sequencer
    typedef struct packed {
        logic in_beat;
        logic last;
        logic single;
        logic scan_done;
        logic end_one;
        logic out_free;
    } t_stat;

    // decoded step strobes from the sequencer
    typedef struct packed {
        logic load_rdy;
        logic start;
        logic scan;
        logic tgt_b;
        logic tgt_e;
        logic swap;
        logic next;
        logic done;
    } t_ctrl;

endpackage

FILE: rtl/core/sstm_ram.sv
`timescale 1ns / 1ps

module sstm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: rtl/core/sstm_cmp.sv
`timescale 1ns / 1ps

// shared compare unit: max scan during sort, pair equality during load
module sstm_cmp (
    input  logic [sstm_pkg::DATA_W-1:0] i_a,
    input  logic [sstm_pkg::DATA_W-1:0] i_b,
    output logic                        o_ge,
    output logic                        o_eq
);

    assign o_ge = (i_a >= i_b);
    assign o_eq = (i_a == i_b);

endmodule

FILE: rtl/core/sstm_ctrl.sv
`timescale 1ns / 1ps

module sstm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  sstm_pkg::t_stat i_stat,
    output sstm_pkg::t_ctrl o_ctrl
);

    sstm_pkg::t_state r_state;
    sstm_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sstm_pkg::S_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sstm_pkg::S_LOAD: begin
                if (i_stat.in_beat && i_stat.last) begin
                    n_state = sstm_pkg::S_START;
                end
            end
            sstm_pkg::S_START: begin
                n_state = i_stat.single ? sstm_pkg::S_DONE : sstm_pkg::S_SCAN;
            end
            sstm_pkg::S_SCAN: begin
                if (i_stat.scan_done) begin
                    n_state = sstm_pkg::S_TGT_B;
                end
            end
            sstm_pkg::S_TGT_B: n_state = sstm_pkg::S_TGT_E;
            sstm_pkg::S_TGT_E: n_state = sstm_pkg::S_SWAP;
            sstm_pkg::S_SWAP:  n_state = sstm_pkg::S_NEXT;
            sstm_pkg::S_NEXT: begin
                n_state = i_stat.end_one ? sstm_pkg::S_DONE : sstm_pkg::S_SCAN;
            end
            sstm_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    n_state = sstm_pkg::S_LOAD;
                end
            end
            default: n_state = sstm_pkg::S_LOAD;
        endcase
    end

    always_comb begin
        o_ctrl = '0;
        unique case (r_state)
            sstm_pkg::S_LOAD:  o_ctrl.load_rdy = 1'b1;
            sstm_pkg::S_START: o_ctrl.start    = 1'b1;
            sstm_pkg::S_SCAN:  o_ctrl.scan     = 1'b1;
            sstm_pkg::S_TGT_B: o_ctrl.tgt_b    = 1'b1;
            sstm_pkg::S_TGT_E: o_ctrl.tgt_e    = 1'b1;
            sstm_pkg::S_SWAP:  o_ctrl.swap     = 1'b1;
            sstm_pkg::S_NEXT:  o_ctrl.next     = 1'b1;
            sstm_pkg::S_DONE:  o_ctrl.done     = 1'b1;
            default:           o_ctrl          = '0;
        endcase
    end

endmodule

FILE: rtl/core/selection_sort_target_match.sv
`timescale 1ns / 1ps

// selection sort with target match check
// input channel (i_valid / o_ready): one beat carries a work value, the target
//   value for the same position and a last flag. beats load at one per cycle
//   into a work memory and a target memory of MAX_ITEMS entries each. beats
//   past capacity are dropped and flagged in too_many.
// the beat flagged last starts the sort; o_ready stays low until it is done.
// each pass scans the unsorted prefix through one compare unit, one memory
//   read per cycle, then swaps the maximum into the end position and updates
//   the count of positions where work equals target.
// each pass has its pace set by the single read port of the work memory.
// output channel (o_valid / i_ready): one beat per last input beat, holding
//   match_seen and too_many in an output register. loading of the next array
//   goes on while that beat waits; a new sort only finishes once it is taken.
// reset clears the counts, the overflow flag and the output valid; memory
//   contents are not cleared, only loaded entries are ever read.
module selection_sort_target_match (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [sstm_pkg::DATA_W-1:0] i_work_value,
    input  logic [sstm_pkg::DATA_W-1:0] i_target_value,
    input  logic                        i_last_item,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic                        o_match_seen,
    output logic                        o_too_many
);

    localparam int DW = sstm_pkg::DATA_W;
    localparam int IW = sstm_pkg::IDX_W;
    localparam int CW = sstm_pkg::CNT_W;

    sstm_pkg::t_ctrl ctrl;
    sstm_pkg::t_stat stat;

    // load side counters
    logic [CW-1:0] r_cnt;
    logic [CW-1:0] r_eq;
    logic          r_ovf;
    logic          r_seen;

    // scan pass registers
    logic [IW-1:0] r_end;
    logic [CW-1:0] r_k;
    logic          r_pv;
    logic [IW-1:0] r_pidx;
    logic [DW-1:0] r_max;
    logic [IW-1:0] r_best;
    logic [DW-1:0] r_wend;
    logic [DW-1:0] r_tb;

    // output register
    logic r_out_valid;
    logic r_out_match;
    logic r_out_tm;

    logic          in_beat;
    logic          has_room;
    logic          issue;
    logic          take_max;
    logic          out_free;
    logic [DW-1:0] cmp_a;
    logic [DW-1:0] cmp_b;
    logic          cmp_ge;
    logic          cmp_eq;

    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [DW-1:0] w_wdata;
    logic [DW-1:0] w_rdata;
    logic          t_we;
    logic [IW-1:0] t_raddr;
    logic [DW-1:0] t_rdata;

    logic          old_b;
    logic          old_e;
    logic          new_b;
    logic          new_e;
    logic [CW:0]   eq_sum;

    assign o_ready  = ctrl.load_rdy;
    assign in_beat  = i_valid && ctrl.load_rdy;
    assign has_room = (r_cnt != CW'(sstm_pkg::MAX_ITEMS));
    assign issue    = ctrl.scan && (r_k <= CW'(r_end));
    assign out_free = !r_out_valid || i_ready;

    // compare unit operands: pair check while loading, max scan while sorting
    assign cmp_a = ctrl.scan ? w_rdata : i_work_value;
    assign cmp_b = ctrl.scan ? r_max   : i_target_value;

    sstm_cmp u_cmp (
        .i_a  (cmp_a),
        .i_b  (cmp_b),
        .o_ge (cmp_ge),
        .o_eq (cmp_eq)
    );

    // ties go to the later position
    assign take_max = (r_pidx == '0) || cmp_ge;

    assign stat.in_beat   = in_beat;
    assign stat.last      = i_last_item;
    assign stat.single    = (r_cnt == CW'(1));
    assign stat.scan_done = r_pv && (r_pidx == r_end);
    assign stat.end_one   = (r_end == IW'(1));
    assign stat.out_free  = out_free;

    sstm_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (stat),
        .o_ctrl  (ctrl)
    );

    // work memory: load writes, then max to end, then old end value to best
    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_cnt[IW-1:0];
        w_wdata = i_work_value;
        priority if (ctrl.load_rdy) begin
            w_we = in_beat && has_room;
        end else if (ctrl.swap) begin
            w_we    = 1'b1;
            w_waddr = r_end;
            w_wdata = r_max;
        end else if (ctrl.next) begin
            w_we    = 1'b1;
            w_waddr = r_best;
            w_wdata = r_wend;
        end else begin
            w_we = 1'b0;
        end
    end

    assign t_we    = in_beat && has_room;
    assign t_raddr = ctrl.tgt_b ? r_best : r_end;

    sstm_ram #(.WIDTH(DW), .DEPTH(sstm_pkg::MAX_ITEMS)) u_work_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_k[IW-1:0]),
        .o_rdata (w_rdata)
    );

    sstm_ram #(.WIDTH(DW), .DEPTH(sstm_pkg::MAX_ITEMS)) u_tgt_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wdata (i_target_value),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    // match count across one swap; t_rdata holds target at end here
    assign old_b  = (r_max  == r_tb);
    assign old_e  = (r_wend == t_rdata);
    assign new_b  = (r_wend == r_tb);
    assign new_e  = (r_max  == t_rdata);
    assign eq_sum = {1'b0, r_eq} + (CW+1)'(new_b) + (CW+1)'(new_e)
                  - (CW+1)'(old_b) - (CW+1)'(old_e);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_eq        <= '0;
            r_ovf       <= 1'b0;
            r_pv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_pv <= issue;
            if (in_beat) begin
                if (has_room) begin
                    r_cnt <= r_cnt + CW'(1);
                    r_eq  <= r_eq + CW'(cmp_eq);
                end else begin
                    r_ovf <= 1'b1;
                end
            end
            if (ctrl.swap) begin
                r_eq <= eq_sum[CW-1:0];
            end
            // a new result beat takes the slot when it is empty or as the old one leaves
            if (ctrl.done && out_free) begin
                r_out_valid <= 1'b1;
                r_cnt       <= '0;
                r_eq        <= '0;
                r_ovf       <= 1'b0;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // sort payload
    always_ff @(posedge i_clk) begin
        r_pidx <= r_k[IW-1:0];
        if (issue) begin
            r_k <= r_k + CW'(1);
        end
        if (ctrl.start) begin
            r_seen <= (r_eq == r_cnt);
            r_end  <= IW'(r_cnt - CW'(1));
            r_k    <= '0;
        end
        if (ctrl.scan && r_pv) begin
            if (take_max) begin
                r_max  <= w_rdata;
                r_best <= r_pidx;
            end
            if (r_pidx == r_end) begin
                r_wend <= w_rdata;
            end
        end
        if (ctrl.tgt_e) begin
            r_tb <= t_rdata;
        end
        if (ctrl.next) begin
            if (r_eq == r_cnt) begin
                r_seen <= 1'b1;
            end
            r_end <= r_end - IW'(1);
            r_k   <= '0;
        end
        if (ctrl.done && out_free) begin
            r_out_match <= r_seen;
            r_out_tm    <= r_ovf;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_match_seen = r_out_match;
    assign o_too_many   = r_out_tm;

endmodule

FILE: rtl/core/sstm_checker.sv
`timescale 1ns / 1ps

module sstm_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_valid,
    input logic                        o_ready,
    input logic [sstm_pkg::DATA_W-1:0] i_work_value,
    input logic [sstm_pkg::DATA_W-1:0] i_target_value,
    input logic                        i_last_item,
    input logic                        o_valid,
    input logic                        i_ready,
    input logic                        o_match_seen,
    input logic                        o_too_many
);

    // a waiting result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_match_seen) && $stable(o_too_many))
        else $error("result beat changed while stalled");

    // a waiting input beat holds its payload
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_ready |=> i_valid && $stable(i_work_value)
            && $stable(i_target_value) && $stable(i_last_item))
        else $error("input beat changed while stalled");

    // loading stays open across beats that are not last
    a_load_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && !i_last_item |=> o_ready)
        else $error("input closed after a non-last beat");

    // the last beat starts the sort, which blocks input
    a_sort_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready && i_last_item |=> !o_ready)
        else $error("input still open after last beat");

    // no result beat right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind selection_sort_target_match sstm_checker u_sstm_checker (.*);
